### design/alb_pkg.sv
// ----------------------------------------------------------------------------
// alb_pkg: shared types and constants
// Types, codes and constants used by the LED bit serializer modules.
// ----------------------------------------------------------------------------
package alb_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int CHAN_W         = 8;
    localparam int TICK_W         = 8;
    localparam int BITCNT_W       = 5;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 8;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_SHORT_TICKS = 2'd0,
        CFG_LONG_TICKS  = 2'd1,
        CFG_INVERTED    = 2'd2
    } cfg_index_t;

    typedef struct packed
    {
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic              inverted;
    } cfg_t;

    typedef struct packed
    {
        logic frame_done;
        logic accepted;
        logic busy;
        logic pin;
    } result_t;

endpackage

### design/alb_scale.sv
// ----------------------------------------------------------------------------
// alb_scale: brightness scaling and channel reorder
// Scales each channel by brightness/255 (truncated) and packs the result
// as green, red, blue with green in the top byte.
// ----------------------------------------------------------------------------
module alb_scale
(
    input  logic [alb_pkg::BITS_PER_PIXEL-1:0] color,
    input  logic [alb_pkg::CHAN_W-1:0]         brightness,
    output logic [alb_pkg::BITS_PER_PIXEL-1:0] grb
);

    logic [2*alb_pkg::CHAN_W-1:0] prod_r;
    logic [2*alb_pkg::CHAN_W-1:0] prod_g;
    logic [2*alb_pkg::CHAN_W-1:0] prod_b;
    logic [alb_pkg::CHAN_W-1:0]   scaled_r;
    logic [alb_pkg::CHAN_W-1:0]   scaled_g;
    logic [alb_pkg::CHAN_W-1:0]   scaled_b;

    // Exact x/255 for any product of two 8-bit values: (x + (x >> 8) + 1) >> 8.
    function automatic logic [alb_pkg::CHAN_W-1:0] div255
    (
        input logic [2*alb_pkg::CHAN_W-1:0] x
    );
        logic [2*alb_pkg::CHAN_W:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    assign prod_r = color[23:16] * brightness;
    assign prod_g = color[15:8] * brightness;
    assign prod_b = color[7:0] * brightness;

    assign scaled_r = div255(prod_r);
    assign scaled_g = div255(prod_g);
    assign scaled_b = div255(prod_b);

    assign grb = {scaled_g, scaled_r, scaled_b};

endmodule

### design/alb_core.sv
// ----------------------------------------------------------------------------
// alb_core: bit serializer state
// Holds the shift word and segment counters and advances them by one beat
// per step, producing one result for each step.
// ----------------------------------------------------------------------------
module alb_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  alb_pkg::op_t                       op,
    input  logic [alb_pkg::BITS_PER_PIXEL-1:0] grb,
    input  logic                               last_pixel,
    input  alb_pkg::cfg_t                      cfg,
    output alb_pkg::result_t                   result
);

    logic [alb_pkg::BITS_PER_PIXEL-1:0] shift_reg;
    logic [alb_pkg::BITS_PER_PIXEL-1:0] shift_next;
    logic [alb_pkg::BITCNT_W-1:0]       bits_left_reg;
    logic [alb_pkg::BITCNT_W-1:0]       bits_left_next;
    logic                               second_reg;
    logic                               second_next;
    logic [alb_pkg::TICK_W-1:0]         ticks_reg;
    logic [alb_pkg::TICK_W-1:0]         ticks_next;
    logic                               sending_reg;
    logic                               sending_next;
    logic                               ending_reg;
    logic                               ending_next;
    logic [alb_pkg::BITS_PER_PIXEL-1:0] shifted;

    // A programmed length of zero behaves as one tick.
    function automatic logic [alb_pkg::TICK_W-1:0] seg_len
    (
        input logic          use_long,
        input alb_pkg::cfg_t c
    );
        logic [alb_pkg::TICK_W-1:0] v;
        v = use_long ? c.long_ticks : c.short_ticks;
        return (v == '0) ? alb_pkg::TICK_W'(1) : v;
    endfunction

    assign shifted = {shift_reg[alb_pkg::BITS_PER_PIXEL-2:0], 1'b0};

    always_comb
    begin
        shift_next      = shift_reg;
        bits_left_next  = bits_left_reg;
        second_next     = second_reg;
        ticks_next      = ticks_reg;
        sending_next    = sending_reg;
        ending_next     = ending_reg;
        result.pin        = cfg.inverted;
        result.accepted   = 1'b0;
        result.frame_done = 1'b0;

        if (op == alb_pkg::OP_PIXEL)
        begin
            if (!sending_reg)
            begin
                shift_next     = grb;
                bits_left_next = alb_pkg::BITCNT_W'(alb_pkg::BITS_PER_PIXEL);
                second_next    = 1'b0;
                ticks_next     = seg_len(grb[alb_pkg::BITS_PER_PIXEL-1], cfg);
                sending_next   = 1'b1;
                ending_next    = last_pixel;
                result.accepted = 1'b1;
            end
        end
        else if (sending_reg)
        begin
            result.pin = second_reg ? cfg.inverted : ~cfg.inverted;
            if (ticks_reg > alb_pkg::TICK_W'(1))
            begin
                ticks_next = ticks_reg - alb_pkg::TICK_W'(1);
            end
            else if (!second_reg)
            begin
                second_next = 1'b1;
                ticks_next  = seg_len(~shift_reg[alb_pkg::BITS_PER_PIXEL-1], cfg);
            end
            else
            begin
                shift_next = shifted;
                if (bits_left_reg <= alb_pkg::BITCNT_W'(1))
                begin
                    bits_left_next    = '0;
                    sending_next      = 1'b0;
                    second_next       = 1'b0;
                    ticks_next        = '0;
                    result.frame_done = ending_reg;
                    ending_next       = 1'b0;
                end
                else
                begin
                    bits_left_next = bits_left_reg - alb_pkg::BITCNT_W'(1);
                    second_next    = 1'b0;
                    ticks_next     = seg_len(shifted[alb_pkg::BITS_PER_PIXEL-1], cfg);
                end
            end
        end

        result.busy = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            bits_left_reg <= '0;
            second_reg    <= 1'b0;
            ticks_reg     <= '0;
            sending_reg   <= 1'b0;
            ending_reg    <= 1'b0;
        end
        else if (step)
        begin
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            second_reg    <= second_next;
            ticks_reg     <= ticks_next;
            sending_reg   <= sending_next;
            ending_reg    <= ending_next;
        end
    end

endmodule

### design/addressable_led_bit_serializer.sv
// ----------------------------------------------------------------------------
// addressable_led_bit_serializer: GRB one-wire LED bit serializer
// Scales pixels by brightness and sends them bit by bit, one level per tick.
// ----------------------------------------------------------------------------
// Path: a beat is held in the input register, then one step through scaler
// and serializer state writes its result into the output register.
// Throughput: one beat per cycle while the receiver takes results; while a
// result waits, the input register still takes one beat.
// Reset: rst_n clears the valid flags and serializer state; short_ticks 1, long_ticks 3, inverted 1.
module addressable_led_bit_serializer
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream: tdata = color[23:0], brightness[31:24]; tuser = op;
    // tlast = last_pixel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // color, brightness
    input  logic                                s_tuser,   // op
    input  logic                                s_tlast,   // last_pixel
    // Result stream: tdata = pin, busy_res, accepted, zero fill; tlast = frame_done.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // pin, busy_res, accepted
    output logic                                m_tlast,   // frame_done
    // Register write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [alb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [alb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                               in_valid_reg;
    alb_pkg::op_t                       op_reg;
    logic [alb_pkg::BITS_PER_PIXEL-1:0] color_reg;
    logic [alb_pkg::CHAN_W-1:0]         bright_reg;
    logic                               last_reg;
    logic                               out_valid_reg;
    alb_pkg::result_t                   out_reg;
    alb_pkg::result_t                   result;
    alb_pkg::cfg_t                      cfg_reg;
    logic [alb_pkg::BITS_PER_PIXEL-1:0] grb;
    logic                               out_free;
    logic                               step;

    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ticks <= alb_pkg::TICK_W'(1);
            cfg_reg.long_ticks  <= alb_pkg::TICK_W'(3);
            cfg_reg.inverted    <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                alb_pkg::CFG_SHORT_TICKS: cfg_reg.short_ticks <= cfg_data;
                alb_pkg::CFG_LONG_TICKS:  cfg_reg.long_ticks  <= cfg_data;
                alb_pkg::CFG_INVERTED:    cfg_reg.inverted    <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg     <= alb_pkg::op_t'(s_tuser);
            color_reg  <= s_tdata[23:0];
            bright_reg <= s_tdata[31:24];
            last_reg   <= s_tlast;
        end
    end

    alb_scale u_scale
    (
        .color      (color_reg),
        .brightness (bright_reg),
        .grb        (grb)
    );

    alb_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .op         (op_reg),
        .grb        (grb),
        .last_pixel (last_reg),
        .cfg        (cfg_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.accepted, out_reg.busy, out_reg.pin};
    assign m_tlast  = out_reg.frame_done;

endmodule

### tb/sv/tb_addressable_led_bit_serializer.sv
// ----------------------------------------------------------------------------
// tb_addressable_led_bit_serializer: self-checking bench for the LED serializer
// Drives pixel and tick beats with random bursts and output stalls, predicts
// every line level, busy, accept and frame-done flag, and checks each result
// beat in order against the prediction, across several timing settings.
// ----------------------------------------------------------------------------
module tb_addressable_led_bit_serializer;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // color[23:0], brightness[31:24]
    logic        s_tuser;   // op
    logic        s_tlast;   // last_pixel
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // pin, busy_res, accepted, zero fill
    logic        m_tlast;   // frame_done
    logic        cfg_valid;
    logic        cfg_ready;
    logic [alb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [alb_pkg::CFG_DATA_W-1:0]  cfg_data;

    addressable_led_bit_serializer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted register settings.
    logic [7:0]  set_short;
    logic [7:0]  set_long;
    logic        set_inverted;

    // Predicted serializer state.
    logic [23:0] grb_word;
    int          bits_to_send;
    logic        in_second_half;
    int          half_ticks_left;
    logic        line_busy;
    logic        ends_frame;

    alb_pkg::result_t expected_levels[$];

    int          mismatches;
    int          results_checked;
    int          pixels_taken;
    int          pixels_rejected;
    int          frames_closed;
    int          burst_left;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [7:0] half_length(logic use_long);
        logic [7:0] v;
        v = use_long ? set_long : set_short;
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [7:0] dim(logic [7:0] chan, logic [7:0] bright);
        int prod;
        prod = int'(chan) * int'(bright);
        return 8'(prod / 255);
    endfunction

    // Advances the predicted serializer by one beat and returns its result.
    function automatic alb_pkg::result_t predict_line(alb_pkg::op_t op, logic [23:0] color,
                                                      logic [7:0] bright, logic last);
        alb_pkg::result_t r;
        r = '0;
        r.pin = set_inverted;
        if (op == alb_pkg::OP_PIXEL)
        begin
            if (!line_busy)
            begin
                grb_word = {dim(color[15:8], bright), dim(color[23:16], bright),
                            dim(color[7:0], bright)};
                bits_to_send = alb_pkg::BITS_PER_PIXEL;
                in_second_half = 1'b0;
                half_ticks_left = half_length(grb_word[23]);
                line_busy = 1'b1;
                ends_frame = last;
                r.accepted = 1'b1;
                pixels_taken++;
            end
            else
            begin
                pixels_rejected++;
            end
        end
        else if (line_busy)
        begin
            r.pin = in_second_half ? set_inverted : ~set_inverted;
            if (half_ticks_left > 1)
            begin
                half_ticks_left--;
            end
            else if (!in_second_half)
            begin
                in_second_half = 1'b1;
                half_ticks_left = half_length(~grb_word[23]);
            end
            else
            begin
                grb_word = grb_word << 1;
                if (bits_to_send <= 1)
                begin
                    bits_to_send = 0;
                    line_busy = 1'b0;
                    in_second_half = 1'b0;
                    half_ticks_left = 0;
                    r.frame_done = ends_frame;
                    if (ends_frame)
                    begin
                        frames_closed++;
                    end
                    ends_frame = 1'b0;
                end
                else
                begin
                    bits_to_send--;
                    in_second_half = 1'b0;
                    half_ticks_left = half_length(grb_word[23]);
                end
            end
        end
        r.busy = line_busy;
        return r;
    endfunction

    // Sends one beat; the sender may idle between bursts of random length.
    task automatic send_beat(alb_pkg::op_t op, logic [23:0] color, logic [7:0] bright,
                             logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bright, color};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        expected_levels.push_back(predict_line(op, color, bright, last));
    endtask

    task automatic tick();
        send_beat(alb_pkg::OP_TICK, 24'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic finish_pixel();
        while (line_busy)
        begin
            tick();
        end
    endtask

    // Waits until every predicted result has come back, so that no beat is left in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_levels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(alb_pkg::cfg_index_t idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            alb_pkg::CFG_SHORT_TICKS: set_short = value;
            alb_pkg::CFG_LONG_TICKS:  set_long = value;
            alb_pkg::CFG_INVERTED:    set_inverted = value[0];
            default:                  ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(logic [7:0] short_len, logic [7:0] long_len, logic inv);
        settle();
        write_reg(alb_pkg::CFG_SHORT_TICKS, short_len);
        write_reg(alb_pkg::CFG_LONG_TICKS, long_len);
        write_reg(alb_pkg::CFG_INVERTED, {7'd0, inv});
    endtask

    task automatic test_idle_ticks();
        int i;
        for (i = 0; i < 3; i++)
        begin
            tick();
        end
    endtask

    // Full-scale white ends a frame; a pixel sent mid-way must be refused.
    task automatic test_full_white_and_reject();
        int i;
        send_beat(alb_pkg::OP_PIXEL, 24'hffffff, 8'hff, 1'b1);
        for (i = 0; i < 10; i++)
        begin
            tick();
        end
        send_beat(alb_pkg::OP_PIXEL, 24'h123456, 8'h80, 1'b0);
        finish_pixel();
        tick();
    endtask

    // Zero brightness blanks any color; odd products check the truncation.
    task automatic test_brightness_scaling();
        set_timing(8'd1, 8'd1, 1'b0);
        send_beat(alb_pkg::OP_PIXEL, 24'hffffff, 8'h00, 1'b0);
        finish_pixel();
        send_beat(alb_pkg::OP_PIXEL, 24'h80ff01, 8'h80, 1'b1);
        finish_pixel();
        send_beat(alb_pkg::OP_PIXEL, 24'h000000, 8'hff, 1'b0);
        finish_pixel();
    endtask

    // Lengths of zero behave as one for both segments.
    task automatic test_zero_lengths();
        set_timing(8'd0, 8'd0, 1'b0);
        test_idle_ticks();
        send_beat(alb_pkg::OP_PIXEL, 24'ha5a5a5, 8'hff, 1'b1);
        finish_pixel();
    endtask

    // A pixel may still be on the line when the next timing setting is written.
    task automatic random_beats(int count);
        int n;
        int pick;
        logic [23:0] color;
        logic [7:0]  bright;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if ((!line_busy && pick < 85) || (line_busy && pick < 6))
            begin
                case ($urandom_range(0, 7))
                    0:       color = 24'hffffff;
                    1:       color = 24'h000000;
                    default: color = 24'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:       bright = 8'hff;
                    1:       bright = 8'h00;
                    default: bright = 8'($urandom);
                endcase
                send_beat(alb_pkg::OP_PIXEL, color, bright, 1'($urandom));
            end
            else
            begin
                tick();
            end
        end
    endtask

    task automatic test_random_timings();
        set_timing(8'd1, 8'd3, 1'b1);
        random_beats(25);
        set_timing(8'd1, 8'd1, 1'b0);
        random_beats(25);
        set_timing(8'd2, 8'd5, 1'b1);
        random_beats(25);
        set_timing(8'd0, 8'd2, 1'b0);
        random_beats(25);
        set_timing(8'd4, 8'd1, 1'b1);
        random_beats(25);
        set_timing(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)), 1'($urandom));
        random_beats(25);
    endtask

    // Receiver stalls change character as bits 8:7 of a free-running phase counter step.
    int ready_phase = 0;
    always @(posedge clk)
    begin
        ready_phase <= ready_phase + 1;
        case (ready_phase[8:7])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (ready_phase[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic report_mismatch(string field, int want, int got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     results_checked, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        alb_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_levels.size() == 0)
            begin
                report_mismatch("unexpected beat", 0, 1);
            end
            else
            begin
                want = expected_levels.pop_front();
                if (m_tdata[0] !== want.pin)
                begin
                    report_mismatch("pin", want.pin, m_tdata[0]);
                end
                if (m_tdata[1] !== want.busy)
                begin
                    report_mismatch("busy_res", want.busy, m_tdata[1]);
                end
                if (m_tdata[2] !== want.accepted)
                begin
                    report_mismatch("accepted", want.accepted, m_tdata[2]);
                end
                if (m_tdata[7:3] !== 5'd0)
                begin
                    report_mismatch("zero fill", 0, m_tdata[7:3]);
                end
                if (m_tlast !== want.frame_done)
                begin
                    report_mismatch("frame_done", want.frame_done, m_tlast);
                end
            end
            results_checked++;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        set_short = 8'd1;
        set_long = 8'd3;
        set_inverted = 1'b1;
        grb_word = '0;
        bits_to_send = 0;
        in_second_half = 1'b0;
        half_ticks_left = 0;
        line_busy = 1'b0;
        ends_frame = 1'b0;
        mismatches = 0;
        results_checked = 0;
        pixels_taken = 0;
        pixels_rejected = 0;
        frames_closed = 0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_full_white_and_reject();
        test_brightness_scaling();
        test_zero_lengths();
        test_random_timings();

        settle();
        if (expected_levels.size() != 0)
        begin
            mismatches++;
        end
        $display("checked %0d result beats: %0d pixels sent, %0d refused while busy,",
                 results_checked, pixels_taken, pixels_rejected);
        $display("%0d frames closed, across nine timing and polarity settings",
                 frames_closed);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", expected_levels.size());
        $display("tb: failure");
        $finish;
    end

endmodule
